/* rtl/sorted_table_binary_search_defines.svh */
// assertion macros used by the sorted table search engine
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// checked while out of reset
`define STB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define STB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/stb_pkg.sv */
// types, constants and codes for the sorted table search block
package stb_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 16;

  typedef enum logic [0:0] {
    FUNC_WRITE  = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STB_IDLE,
    STB_SEARCH,
    STB_FINISH
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [IDX_W+1:0] bound_t;

  typedef struct packed {
    idx_t                    low;
    idx_t                    high;
    logic signed [VAL_W-1:0] key;
  } search_req_t;

  typedef struct packed {
    logic found;
    idx_t match_index;
  } search_res_t;

endpackage

/* rtl/stb_ram.sv */
// generic single-port-write, registered-read ram
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/stb_engine.sv */
// binary search sequencer: one table read and one compare per step
`include "sorted_table_binary_search_defines.svh"

module stb_engine #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  stb_pkg::search_req_t            req,
  output logic                            busy,
  output logic                            res_valid,
  input  logic                            res_ready,
  output stb_pkg::search_res_t            res,
  output logic                            rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
  input  logic [stb_pkg::VAL_W-1:0]       rd_data
);

  import stb_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t                  state, state_next;
  bound_t                  lo, lo_next;
  bound_t                  hi, hi_next;
  idx_t                    mid, mid_next;
  logic signed [VAL_W-1:0] key, key_next;
  logic                    found, found_next;
  idx_t                    match_idx, match_idx_next;

  bound_t                  lo_in, hi_in, sum;
  idx_t                    hi_sat;
  logic [IDX_W+AW-1:0]     addr_wide;
  logic signed [VAL_W-1:0] entry;

  assign hi_sat = (int'(req.high) > (TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1) : req.high;
  assign lo_in  = bound_t'({2'b00, req.low});
  assign hi_in  = bound_t'({2'b00, hi_sat});
  assign entry  = $signed(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STB_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    key       <= key_next;
    found     <= found_next;
    match_idx <= match_idx_next;
  end

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    key_next       = key;
    found_next     = found;
    match_idx_next = match_idx;
    rd_en          = 1'b0;
    res_valid      = 1'b0;
    unique case (state)
      STB_IDLE: begin
        if (start) begin
          lo_next        = lo_in;
          hi_next        = hi_in;
          key_next       = req.key;
          found_next     = 1'b0;
          match_idx_next = '0;
          if (lo_in <= hi_in) begin
            rd_en      = 1'b1;
            state_next = STB_SEARCH;
          end else begin
            state_next = STB_FINISH;
          end
        end
      end
      STB_SEARCH: begin
        if (key == entry) begin
          found_next     = 1'b1;
          match_idx_next = mid;
          state_next     = STB_FINISH;
        end else begin
          if (key > entry) begin
            lo_next = bound_t'({2'b00, mid}) + bound_t'(1);
          end else begin
            hi_next = bound_t'({2'b00, mid}) - bound_t'(1);
          end
          if (lo_next <= hi_next) begin
            rd_en = 1'b1;
          end else begin
            state_next = STB_FINISH;
          end
        end
      end
      STB_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = STB_IDLE;
        end
      end
      default: state_next = STB_IDLE;
    endcase
    sum = lo_next + hi_next;
    if (rd_en) begin
      mid_next = sum[IDX_W:1];
    end
  end

  assign addr_wide       = {{AW{1'b0}}, mid_next};
  assign rd_addr         = addr_wide[AW-1:0];
  assign busy            = (state != STB_IDLE);
  assign res.found       = found;
  assign res.match_index = match_idx;

  `STB_ASSERT(a_range_live, (state == STB_SEARCH) |-> (lo <= hi), "search step with empty range")
  `STB_ASSERT(a_mid_in_range,
    (state == STB_SEARCH) |-> (bound_t'({2'b00, mid}) >= lo && bound_t'({2'b00, mid}) <= hi),
    "probe index outside range")
  `STB_ASSERT(a_result_holds, (res_valid && !res_ready) |=> (res_valid && $stable(res)),
    "result changed while stalled")
  `STB_ASSERT_ALWAYS(a_reset_idle, rst |=> (!res_valid && !busy), "engine not idle after reset")

endmodule

/* rtl/sorted_table_binary_search.sv */
// top level of the sorted table binary search block
//
// input stream s_*: one beat is a write or a search, chosen by s_tuser.
//   a write stores entry_value at entry_index; writes at or past
//   the table depth are dropped. writes give no output beat.
//   a search looks for search_key in the inclusive range search_low to
//   search_high (high saturated to the last entry) and gives one output beat.
// output stream m_*: found on m_tuser, match_index on m_tdata (0 when not found).
// a search runs k halving steps before its result is offered, where k is
//   at most ceil(log2(range + 1)), 11 for a full 1024-entry table; an
//   empty or reversed range gives k = 0.
// searches do not overlap; writes are taken one per cycle while s_tready is high. each
//   halving step is one registered read of the table ram and one compare.
// s_tready is low while a search runs and while its result waits for the
//   output register; a stalled m_tready holds the beat and the next search
//   stops before delivery; writes are accepted only while no search is in the engine.
// reset clears the control state; table contents stay undefined until written.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stb_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // entry_index, entry_value, search_low, search_high, search_key, zero pad
  input  logic [stb_pkg::S_DATA_W-1:0]  s_tdata,
  // func
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // match_index, zero pad
  output logic [stb_pkg::M_DATA_W-1:0]  m_tdata,
  // found
  output logic                          m_tuser
);

  import stb_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  idx_t                entry_index;
  logic [VAL_W-1:0]    entry_value;
  search_req_t         req;
  logic                s_fire, busy;
  logic                wr_en;
  logic [IDX_W+AW-1:0] waddr_wide;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [VAL_W-1:0]    rd_data;
  logic                res_valid, res_ready;
  search_res_t         res;
  logic                m_tvalid_next;
  search_res_t         out_beat;

  assign entry_index = s_tdata[9:0];
  assign entry_value = s_tdata[41:10];
  assign req.low     = s_tdata[51:42];
  assign req.high    = s_tdata[61:52];
  assign req.key     = $signed(s_tdata[93:62]);

  assign s_tready   = !busy;
  assign s_fire     = s_tvalid && s_tready;
  assign wr_en      = s_fire && (func_t'(s_tuser) == FUNC_WRITE)
                      && (int'(entry_index) < TABLE_DEPTH);
  assign waddr_wide = {{AW{1'b0}}, entry_index};

  stb_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr_wide[AW-1:0]),
    .wdata (entry_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  stb_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_fire && (func_t'(s_tuser) == FUNC_SEARCH)),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign res_ready     = !m_tvalid || m_tready;
  assign m_tvalid_next = (res_valid && res_ready) || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_beat <= res;
    end
  end

  assign m_tdata = {{(M_DATA_W - IDX_W){1'b0}}, out_beat.match_index};
  assign m_tuser = out_beat.found;

endmodule
